>>> src/uart_register_bank_defines.svh
// Assertion macros used by the UART register bank RTL.
// Both sample on posedge clk and are disabled while rst_n is low.
`ifndef UART_REGISTER_BANK_DEFINES_SVH
`define UART_REGISTER_BANK_DEFINES_SVH

`ifndef SYNTHESIS

`define URB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define URB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define URB_ASSERT_IMPL(label, ante, cons)

`define URB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/urb_pkg.sv
`default_nettype none

package urb_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RECV  = 2'd2;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_LOAD  = 2'd1;
    localparam logic [1:0] FAULT_STORE = 2'd2;

    localparam logic [3:0] SIZE_BYTE = 4'd1;

    localparam logic [7:0] DATA_READY_MASK = 8'h01;
    localparam logic [7:0] TX_EMPTY_MASK   = 8'h20;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_SEMICOLON  = 8'h3B;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } bank_wr_t;

endpackage

`default_nettype wire

>>> src/uart_register_bank.sv
`default_nettype none

// 16550-style UART register bank. Each item is a bus read, a bus write, a
// character from the line or an unused opcode that does nothing, and yields
// exactly one result. One item is accepted per cycle while the result side
// keeps up. The item is registered in the input register at the accepting edge,
// and its result register is loaded once the result side can take it. The bank
// memory is read at the accepting edge, so its registered data waits with the
// item. A stalled result holds the item and stops intake until it is taken. The
// holding and status bytes live in flip-flops, the rest in a memory whose
// per-entry valid bits clear at reset, so items are taken right after reset
// with no clearing pass. Reads and writes of a size other than one byte fault.
module uart_register_bank #(
    parameter int REG_BYTES     = 256,
    parameter int HOLD_OFFSET   = 0,
    parameter int STATUS_OFFSET = 5
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] opcode,
    input  wire logic [7:0] reg_offset,
    input  wire logic [3:0] access_size,
    input  wire logic [7:0] write_data,
    input  wire logic [7:0] rx_char,
    input  wire logic       irq_clear,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      read_data,
    output logic [1:0]      fault,
    output logic            tx_valid,
    output logic [7:0]      tx_char,
    output logic            rx_accepted,
    output logic            irq_pending
);

`include "uart_register_bank_defines.svh"

    localparam int         MEM_DEPTH  = (REG_BYTES > 256) ? 256 : REG_BYTES;
    localparam bit         HOLD_IN    = (HOLD_OFFSET < REG_BYTES);
    localparam bit         STAT_IN    = (STATUS_OFFSET < REG_BYTES);
    localparam bit         SAME       = (HOLD_OFFSET == STATUS_OFFSET);
    localparam logic [7:0] HOLD_OFF8  = 8'(HOLD_OFFSET);
    localparam logic [7:0] STAT_OFF8  = 8'(STATUS_OFFSET);
    localparam logic [7:0] STAT_RESET = STAT_IN ? urb_pkg::TX_EMPTY_MASK : 8'h00;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] fault;
        logic       tx_valid;
        logic [7:0] tx_char;
        logic       rx_accepted;
        logic       irq_pending;
    } result_t;

    logic       s1_valid_reg;
    logic [1:0] s1_op_reg;
    logic [7:0] s1_off_reg;
    logic [3:0] s1_size_reg;
    logic [7:0] s1_wdata_reg;
    logic [7:0] s1_rx_reg;
    logic       s1_clr_reg;

    logic       out_valid_reg;
    result_t    res_reg;
    result_t    res_next;

    logic [7:0] hold_reg;
    logic [7:0] hold_next;
    logic [7:0] status_reg;
    logic [7:0] status_next;
    logic       irq_reg;
    logic       irq_next;
    logic       irq_eff;

    logic       accept;
    logic       s1_adv;

    urb_pkg::bank_wr_t bank_wr;
    logic [7:0] bank_rdata;

    logic       size_ok;
    logic       off_hold;
    logic       off_stat;
    logic       off_in;
    logic [7:0] hold_cur;
    logic [7:0] stat_cur;
    logic [7:0] stat_rd;
    logic [7:0] rx_mapped;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    urb_bank_mem #(
        .DEPTH (MEM_DEPTH)
    ) u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (reg_offset),
        .wr      (bank_wr),
        .rd_data (bank_rdata)
    );

    assign size_ok  = (s1_size_reg == urb_pkg::SIZE_BYTE);
    assign off_hold = (s1_off_reg == HOLD_OFF8);
    assign off_stat = (s1_off_reg == STAT_OFF8);
    assign off_in   = (int'(s1_off_reg) < REG_BYTES);
    assign stat_cur = STAT_IN ? status_reg : 8'h00;
    assign hold_cur = HOLD_IN ? (SAME ? status_reg : hold_reg) : 8'h00;
    assign stat_rd  = stat_cur & ~urb_pkg::DATA_READY_MASK;

    always_comb
    begin
        case (s1_rx_reg)
            urb_pkg::CHAR_UNDERSCORE: rx_mapped = urb_pkg::CHAR_SPACE;
            urb_pkg::CHAR_SEMICOLON:  rx_mapped = urb_pkg::CHAR_NEWLINE;
            default:                  rx_mapped = s1_rx_reg;
        endcase
    end

    always_comb
    begin
        res_next     = '0;
        status_next  = status_reg;
        hold_next    = hold_reg;
        irq_eff      = irq_reg;
        bank_wr      = '0;
        bank_wr.addr = s1_off_reg;
        bank_wr.data = s1_wdata_reg;
        case (s1_op_reg)
            urb_pkg::OP_READ:
            begin
                if (!size_ok)
                begin
                    res_next.fault = urb_pkg::FAULT_LOAD;
                end
                else if (off_hold)
                begin
                    if (STAT_IN)
                    begin
                        status_next = stat_rd;
                    end
                    res_next.read_data = SAME ? stat_rd : hold_cur;
                end
                else if (off_stat)
                begin
                    res_next.read_data = stat_cur;
                end
                else if (off_in)
                begin
                    res_next.read_data = bank_rdata;
                end
            end
            urb_pkg::OP_WRITE:
            begin
                if (!size_ok)
                begin
                    res_next.fault = urb_pkg::FAULT_STORE;
                end
                else if (off_hold)
                begin
                    res_next.tx_valid = 1'b1;
                    res_next.tx_char  = s1_wdata_reg;
                end
                else if (off_stat)
                begin
                    if (STAT_IN)
                    begin
                        status_next = s1_wdata_reg;
                    end
                end
                else if (off_in)
                begin
                    bank_wr.en = s1_adv;
                end
            end
            urb_pkg::OP_RECV:
            begin
                if ((stat_cur & urb_pkg::DATA_READY_MASK) == 8'h00)
                begin
                    if (HOLD_IN)
                    begin
                        hold_next = rx_mapped;
                    end
                    if (STAT_IN)
                    begin
                        status_next = (SAME ? rx_mapped : stat_cur) | urb_pkg::DATA_READY_MASK;
                    end
                    irq_eff              = 1'b1;
                    res_next.rx_accepted = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res_next.irq_pending = irq_eff;
        irq_next             = s1_clr_reg ? 1'b0 : irq_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= STAT_RESET;
            hold_reg      <= 8'h00;
            irq_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= status_next;
                hold_reg      <= hold_next;
                irq_reg       <= irq_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= opcode;
            s1_off_reg   <= reg_offset;
            s1_size_reg  <= access_size;
            s1_wdata_reg <= write_data;
            s1_rx_reg    <= rx_char;
            s1_clr_reg   <= irq_clear;
        end
        if (s1_adv)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = res_reg.read_data;
    assign fault       = res_reg.fault;
    assign tx_valid    = res_reg.tx_valid;
    assign tx_char     = res_reg.tx_char;
    assign rx_accepted = res_reg.rx_accepted;
    assign irq_pending = res_reg.irq_pending;

    `URB_ASSERT_IMPL(a_tx_no_fault, out_valid_reg && res_reg.tx_valid, (res_reg.fault == urb_pkg::FAULT_NONE) && !res_reg.rx_accepted)
    `URB_ASSERT_IMPL(a_rx_needs_empty, s1_adv && res_next.rx_accepted, (stat_cur & urb_pkg::DATA_READY_MASK) == 8'h00)
    `URB_ASSERT_NEXT(a_rx_sets_ready, s1_adv && res_next.rx_accepted, !STAT_IN || status_reg[0])
    `URB_ASSERT_NEXT(a_s1_holds, s1_valid_reg && !s1_adv, s1_valid_reg && out_valid_reg)
    `URB_ASSERT_IMPL(a_fault_no_write, s1_valid_reg && (res_next.fault != urb_pkg::FAULT_NONE), !bank_wr.en && (status_next == status_reg))

endmodule

`default_nettype wire

>>> src/urb_bank_mem.sv
`default_nettype none

// Byte bank with registered read, per-entry valid bits (unwritten reads as 0)
// and write-to-read forwarding for a read issued on the same edge as a write.
module urb_bank_mem #(
    parameter int DEPTH = 256
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [7:0]       rd_addr,
    input  wire urb_pkg::bank_wr_t wr,
    output logic [7:0]            rd_data
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]        mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [7:0]        q_reg;
    logic [7:0]        fwd_data_reg;
    logic              fwd_reg;
    logic              hit_reg;

    logic [ADDR_W-1:0] rd_idx;
    logic [ADDR_W-1:0] wr_idx;
    logic              rd_in;
    logic              wr_in;
    logic              wr_ok;

    assign rd_idx = rd_addr[ADDR_W-1:0];
    assign wr_idx = wr.addr[ADDR_W-1:0];
    assign rd_in  = (int'(rd_addr) < DEPTH);
    assign wr_in  = (int'(wr.addr) < DEPTH);
    assign wr_ok  = wr.en && wr_in;

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_idx] <= wr.data;
        end
        if (rd_en && rd_in)
        begin
            q_reg <= mem[rd_idx];
        end
        if (rd_en)
        begin
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fwd_reg   <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                fwd_reg <= wr_ok && (wr.addr == rd_addr);
                hit_reg <= rd_in && valid_reg[rd_idx];
            end
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : (hit_reg ? q_reg : 8'h00);

endmodule

`default_nettype wire

>>> bench/tb_uart_register_bank.sv
`default_nettype none

module tb_uart_register_bank;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NONE    = 2'd3;
    localparam logic [7:0] HOLD_OFS   = 8'd0;
    localparam logic [7:0] STATUS_OFS = 8'd5;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         TAIL_CYCLES = 8;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] reg_offset;
        logic [3:0] access_size;
        logic [7:0] write_data;
        logic [7:0] rx_char;
        logic       irq_clear;
    } uart_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] fault;
        logic       tx_valid;
        logic [7:0] tx_char;
        logic       rx_accepted;
        logic       irq_pending;
    } uart_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] opcode = '0;
    logic [7:0] reg_offset = '0;
    logic [3:0] access_size = '0;
    logic [7:0] write_data = '0;
    logic [7:0] rx_char = '0;
    logic       irq_clear = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_data;
    logic [1:0] fault;
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       rx_accepted;
    logic       irq_pending;

    logic [7:0]   bank_model [256];
    logic         irq_model;
    uart_result_t expected_results [$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           send_gap_pct = 0;
    int           recv_stall_pct = 0;

    uart_register_bank uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .reg_offset  (reg_offset),
        .access_size (access_size),
        .write_data  (write_data),
        .rx_char     (rx_char),
        .irq_clear   (irq_clear),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .fault       (fault),
        .tx_valid    (tx_valid),
        .tx_char     (tx_char),
        .rx_accepted (rx_accepted),
        .irq_pending (irq_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic uart_item_t make_item(input logic [1:0] op, input logic [7:0] ofs,
                                             input logic [3:0] size, input logic [7:0] wdata,
                                             input logic [7:0] rch, input logic clr);
        uart_item_t it;
        it.opcode      = op;
        it.reg_offset  = ofs;
        it.access_size = size;
        it.write_data  = wdata;
        it.rx_char     = rch;
        it.irq_clear   = clr;
        return it;
    endfunction

    function automatic uart_result_t predict_access(input uart_item_t it);
        uart_result_t r;
        logic [7:0]   c;
        r = '0;
        case (it.opcode)
            urb_pkg::OP_READ:
            begin
                if (it.access_size != urb_pkg::SIZE_BYTE)
                    r.fault = urb_pkg::FAULT_LOAD;
                else if (it.reg_offset == HOLD_OFS)
                begin
                    bank_model[STATUS_OFS] = bank_model[STATUS_OFS]
                                             & ~urb_pkg::DATA_READY_MASK;
                    r.read_data = bank_model[HOLD_OFS];
                end
                else
                    r.read_data = bank_model[it.reg_offset];
            end
            urb_pkg::OP_WRITE:
            begin
                if (it.access_size != urb_pkg::SIZE_BYTE)
                    r.fault = urb_pkg::FAULT_STORE;
                else if (it.reg_offset == HOLD_OFS)
                begin
                    r.tx_valid = 1'b1;
                    r.tx_char  = it.write_data;
                end
                else
                    bank_model[it.reg_offset] = it.write_data;
            end
            urb_pkg::OP_RECV:
            begin
                if ((bank_model[STATUS_OFS] & urb_pkg::DATA_READY_MASK) == 8'h00)
                begin
                    c = it.rx_char;
                    if (c == urb_pkg::CHAR_UNDERSCORE)
                        c = urb_pkg::CHAR_SPACE;
                    else if (c == urb_pkg::CHAR_SEMICOLON)
                        c = urb_pkg::CHAR_NEWLINE;
                    bank_model[HOLD_OFS] = c;
                    irq_model = 1'b1;
                    bank_model[STATUS_OFS] = bank_model[STATUS_OFS]
                                             | urb_pkg::DATA_READY_MASK;
                    r.rx_accepted = 1'b1;
                end
            end
            default: ;
        endcase
        r.irq_pending = irq_model;
        if (it.irq_clear)
            irq_model = 1'b0;
        return r;
    endfunction

    function automatic uart_item_t random_item();
        uart_item_t it;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 35)
            it.opcode = urb_pkg::OP_READ;
        else if (pick < 65)
            it.opcode = urb_pkg::OP_WRITE;
        else if (pick < 95)
            it.opcode = urb_pkg::OP_RECV;
        else
            it.opcode = OP_NONE;
        pick = $urandom_range(99);
        if (pick < 30)
            it.reg_offset = HOLD_OFS;
        else if (pick < 45)
            it.reg_offset = STATUS_OFS;
        else
            it.reg_offset = 8'($urandom_range(255));
        it.access_size = ($urandom_range(99) < 85) ? urb_pkg::SIZE_BYTE
                                                   : 4'($urandom_range(15));
        it.write_data  = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 20)
            it.rx_char = urb_pkg::CHAR_UNDERSCORE;
        else if (pick < 30)
            it.rx_char = urb_pkg::CHAR_SEMICOLON;
        else
            it.rx_char = 8'($urandom_range(255));
        it.irq_clear = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch on %s at cycle %0d: got %h, expected %h",
                 what, cycle_count, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        uart_result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 8'h00, 8'h00);
            else
            begin
                want = expected_results.pop_front();
                if (read_data !== want.read_data)
                    report_mismatch("read_data", read_data, want.read_data);
                if (fault !== want.fault)
                    report_mismatch("fault", 8'(fault), 8'(want.fault));
                if (tx_valid !== want.tx_valid)
                    report_mismatch("tx_valid", 8'(tx_valid), 8'(want.tx_valid));
                if (tx_char !== want.tx_char)
                    report_mismatch("tx_char", tx_char, want.tx_char);
                if (rx_accepted !== want.rx_accepted)
                    report_mismatch("rx_accepted", 8'(rx_accepted), 8'(want.rx_accepted));
                if (irq_pending !== want.irq_pending)
                    report_mismatch("irq_pending", 8'(irq_pending), 8'(want.irq_pending));
            end
        end
    end

    task automatic send_item(input uart_item_t it);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= it.opcode;
        reg_offset  <= it.reg_offset;
        access_size <= it.access_size;
        write_data  <= it.write_data;
        rx_char     <= it.rx_char;
        irq_clear   <= it.irq_clear;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        expected_results.push_back(predict_access(it));
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic test_reset_state();
        send_item(make_item(urb_pkg::OP_READ, STATUS_OFS, urb_pkg::SIZE_BYTE,
                            8'h00, 8'h00, 1'b0));
        send_item(make_item(urb_pkg::OP_READ, 8'hFF, urb_pkg::SIZE_BYTE,
                            8'h00, 8'h00, 1'b0));
        send_item(make_item(urb_pkg::OP_READ, HOLD_OFS, urb_pkg::SIZE_BYTE,
                            8'h00, 8'h00, 1'b0));
    endtask

    task automatic test_bank_access();
        send_item(make_item(urb_pkg::OP_WRITE, 8'hFF, urb_pkg::SIZE_BYTE,
                            8'hA5, 8'h00, 1'b0));
        send_item(make_item(urb_pkg::OP_READ, 8'hFF, urb_pkg::SIZE_BYTE,
                            8'h00, 8'h00, 1'b0));
        send_item(make_item(urb_pkg::OP_WRITE, 8'h01, urb_pkg::SIZE_BYTE,
                            8'h5A, 8'h00, 1'b0));
        send_item(make_item(urb_pkg::OP_READ, 8'h01, urb_pkg::SIZE_BYTE,
                            8'h00, 8'h00, 1'b0));
    endtask

    task automatic test_size_faults();
        send_item(make_item(urb_pkg::OP_READ, 8'hFF, 4'd0, 8'h00, 8'h00, 1'b0));
        send_item(make_item(urb_pkg::OP_READ, HOLD_OFS, 4'd15, 8'h00, 8'h00, 1'b0));
        send_item(make_item(urb_pkg::OP_WRITE, 8'hFF, 4'd8, 8'h00, 8'h00, 1'b0));
        send_item(make_item(urb_pkg::OP_WRITE, HOLD_OFS, 4'd2, 8'h77, 8'h00, 1'b0));
        send_item(make_item(urb_pkg::OP_READ, 8'hFF, urb_pkg::SIZE_BYTE,
                            8'h00, 8'h00, 1'b0));
    endtask

    task automatic test_transmit();
        send_item(make_item(urb_pkg::OP_WRITE, HOLD_OFS, urb_pkg::SIZE_BYTE,
                            8'hFF, 8'h00, 1'b0));
        send_item(make_item(urb_pkg::OP_WRITE, HOLD_OFS, urb_pkg::SIZE_BYTE,
                            8'h00, 8'h00, 1'b0));
    endtask

    task automatic test_receive();
        send_item(make_item(urb_pkg::OP_RECV, 8'hFF, 4'd15, 8'hFF,
                            urb_pkg::CHAR_UNDERSCORE, 1'b0));
        send_item(make_item(urb_pkg::OP_RECV, HOLD_OFS, urb_pkg::SIZE_BYTE,
                            8'h00, 8'h78, 1'b0));
        send_item(make_item(urb_pkg::OP_READ, HOLD_OFS, urb_pkg::SIZE_BYTE,
                            8'h00, 8'h00, 1'b1));
        send_item(make_item(urb_pkg::OP_READ, STATUS_OFS, urb_pkg::SIZE_BYTE,
                            8'h00, 8'h00, 1'b0));
        send_item(make_item(urb_pkg::OP_RECV, HOLD_OFS, urb_pkg::SIZE_BYTE,
                            8'h00, urb_pkg::CHAR_SEMICOLON, 1'b0));
        send_item(make_item(urb_pkg::OP_READ, HOLD_OFS, urb_pkg::SIZE_BYTE,
                            8'h00, 8'h00, 1'b0));
        send_item(make_item(urb_pkg::OP_RECV, HOLD_OFS, urb_pkg::SIZE_BYTE,
                            8'h00, 8'hFF, 1'b1));
        send_item(make_item(urb_pkg::OP_READ, HOLD_OFS, urb_pkg::SIZE_BYTE,
                            8'h00, 8'h00, 1'b1));
    endtask

    task automatic test_unused_opcode();
        send_item(make_item(OP_NONE, 8'hFF, 4'd15, 8'hFF, 8'hFF, 1'b0));
        send_item(make_item(OP_NONE, HOLD_OFS, urb_pkg::SIZE_BYTE, 8'h00, 8'h00, 1'b1));
    endtask

    task automatic test_status_write();
        send_item(make_item(urb_pkg::OP_WRITE, STATUS_OFS, urb_pkg::SIZE_BYTE,
                            8'h21, 8'h00, 1'b0));
        send_item(make_item(urb_pkg::OP_RECV, HOLD_OFS, urb_pkg::SIZE_BYTE,
                            8'h00, 8'h41, 1'b0));
        send_item(make_item(urb_pkg::OP_WRITE, STATUS_OFS, urb_pkg::SIZE_BYTE,
                            8'h20, 8'h00, 1'b0));
        send_item(make_item(urb_pkg::OP_RECV, HOLD_OFS, urb_pkg::SIZE_BYTE,
                            8'h00, 8'h42, 1'b1));
    endtask

    task automatic test_random(input int count);
        repeat (count)
            send_item(random_item());
    endtask

    initial
    begin
        for (int i = 0; i < 256; i++)
            bank_model[i] = 8'h00;
        bank_model[STATUS_OFS] = urb_pkg::TX_EMPTY_MASK;
        irq_model = 1'b0;

        send_gap_pct   = 31;
        recv_stall_pct = 63;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_bank_access();
        test_size_faults();
        test_transmit();
        test_receive();
        wait_results_done();
        test_unused_opcode();
        test_status_write();
        test_random(340);
        wait_results_done();

        send_gap_pct   = 63;
        recv_stall_pct = 31;
        test_random(330);
        wait_results_done();

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random(330);
        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> uart_register_bank.f
+incdir+src
src/urb_pkg.sv
src/urb_bank_mem.sv
src/uart_register_bank.sv
bench/tb_uart_register_bank.sv
